// ----- sv/tpp_pkg.sv -----
// Shared types and constants for the time period parser.
package tpp_pkg;

  localparam int unsigned DIV_W   = 52;          // widest section value
  localparam int unsigned DIV_NIB = DIV_W / 4;   // dividend nibbles per divide by ten
  localparam int unsigned MUL_W   = 20;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNEXPECTED = 2'd1;
  localparam logic [1:0] ST_TOO_BIG    = 2'd2;

  localparam logic [7:0] MASK_DOT  = 8'h80;
  localparam logic [7:0] MASK_FRAC = 8'h40;
  localparam logic [7:0] MASK_BOTH = 8'hC0;

  localparam logic [MUL_W-1:0] SEC_WEEK = MUL_W'(7 * 24 * 3600);
  localparam logic [MUL_W-1:0] SEC_DAY  = MUL_W'(24 * 3600);
  localparam logic [MUL_W-1:0] SEC_HOUR = MUL_W'(3600);
  localparam logic [MUL_W-1:0] HR_WEEK  = MUL_W'(7 * 24);
  localparam logic [MUL_W-1:0] HR_DAY   = MUL_W'(24);
  localparam logic [MUL_W-1:0] SEC_MIN  = MUL_W'(60);

  typedef enum logic [2:0] {
    PH_LEAD, PH_WANT_DIGIT, PH_AFTER_SECTION, PH_NUM, PH_NUM_BLANK, PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_APPLY, S_DIV, S_FRAC
  } seq_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [3:0]       rem;
  } div_rsp_t;

endpackage

// ----- sv/time_period_parser.sv -----
// Top level of the time period parser.
// Takes a duration string one byte per beat and gives one result beat when the
// string is decided. Digits, blanks, '.', end of string and bad bytes are handled
// as they are taken. A unit byte is multiplied, then used to update the total,
// and no new byte is taken meanwhile; a unit after a fraction of k digits also
// runs k divides by ten through the divider, then adds the rounded fraction (k
// stops counting at 31). No byte is taken while a result beat waits on
// out_stall. The user must write hours_mode through the cfg port only while
// the block is idle; the block itself does not enforce it.
module time_period_parser
  import tpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_period,
  output logic [7:0]  out_bad_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_hours_mode
);

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  seq_t   st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [7:0]       mask_r, mask_nxt, cm_r, cm_nxt, ch_r, ch_nxt;
  logic [31:0]      tot_r, tot_nxt, num_r, num_nxt;
  logic [4:0]       dc_r, dc_nxt, dn_r, dn_nxt;
  logic [MUL_W-1:0] mul_r, mul_nxt, max_r, max_nxt;
  logic [DIV_W-1:0] v_r, v_nxt, tm_r, tm_nxt;
  logic             hm_r;
  logic             ov_r, ov_nxt;
  logic [1:0]       os_r, os_nxt;
  logic [31:0]      op_r, op_nxt;
  logic [7:0]       ob_r, ob_nxt;
  div_req_t         dreq;
  div_rsp_t         drsp;

  tpp_div10 u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_period = op_r;
  assign out_bad_char = ob_r;

  always_comb begin
    logic [7:0]  c, lc, chk;
    logic        blank, digit, acc;
    logic [35:0] n10;
    logic [52:0] sum;
    logic        fin;
    logic [1:0]  fst;
    logic [31:0] fper;
    logic [7:0]  fbad, fbyte;

    c     = in_char_code;
    lc    = c | 8'h20;
    blank = (c == 8'h20) || (c == 8'h09);
    digit = (c >= 8'h30) && (c <= 8'h39);
    acc   = in_valid && !in_stall;
    n10   = {4'd0, num_r} * 36'd10 + {32'd0, c[3:0]};
    sum   = '0;
    chk   = '0;
    fin   = 1'b0;
    fst   = ST_OK;
    fper  = '0;
    fbad  = '0;
    fbyte = c;

    st_nxt   = st_r;
    ph_nxt   = ph_r;
    mask_nxt = mask_r;
    cm_nxt   = cm_r;
    ch_nxt   = ch_r;
    tot_nxt  = tot_r;
    num_nxt  = num_r;
    dc_nxt   = dc_r;
    dn_nxt   = dn_r;
    mul_nxt  = mul_r;
    max_nxt  = max_r;
    v_nxt    = v_r;
    tm_nxt   = tm_r;
    ov_nxt   = ov_r && out_stall;
    os_nxt   = os_r;
    op_nxt   = op_r;
    ob_nxt   = ob_r;
    dreq.start    = 1'b0;
    dreq.dividend = drsp.quo;

    case (st_r)
      S_IDLE: begin
        if (acc) begin
          case (ph_r)
            PH_DRAIN: begin
              if (c == 8'h00) ph_nxt = PH_LEAD;
            end
            PH_WANT_DIGIT: begin
              if (digit) begin
                num_nxt = {28'd0, c[3:0]};
                dc_nxt  = 5'd1;
                ph_nxt  = PH_NUM;
              end else begin
                fin = 1'b1; fst = ST_UNEXPECTED; fbad = c;
              end
            end
            PH_AFTER_SECTION: begin
              if (blank) begin
              end else if (c == 8'h00 || c == 8'h0D || c == 8'h0A) begin
                fin = 1'b1; fst = ST_OK; fper = tot_r;
              end else if (digit && (mask_r & MASK_BOTH) != MASK_BOTH) begin
                num_nxt = {28'd0, c[3:0]};
                dc_nxt  = 5'd1;
                ph_nxt  = PH_NUM;
              end else begin
                fin = 1'b1; fst = ST_UNEXPECTED; fbad = c;
              end
            end
            PH_NUM, PH_NUM_BLANK: begin
              if (ph_r == PH_NUM && digit && num_r != U32_MAX) begin
                num_nxt = n10[31:0];
                if (dc_r != 5'd31) dc_nxt = dc_r + 5'd1;
                if (n10 > {4'd0, U32_MAX}) begin
                  fin = 1'b1; fst = ST_TOO_BIG;
                end
              end else if (blank) begin
                ph_nxt = PH_NUM_BLANK;
              end else if (c == 8'h2E) begin
                if (mask_r != 8'h00) begin
                  fin = 1'b1; fst = ST_UNEXPECTED; fbad = c;
                end else begin
                  mask_nxt = MASK_DOT;
                  tot_nxt  = num_r;
                  ph_nxt   = PH_WANT_DIGIT;
                end
              end else if (c == 8'h00) begin
                fin = 1'b1;
                if (mask_r == 8'h00) begin
                  fst = ST_OK; fper = num_r;
                end else begin
                  fst = ST_UNEXPECTED;
                end
              end else begin
                ch_nxt = c;
                st_nxt = S_MUL;
                case (lc)
                  8'h77: begin
                    mul_nxt = hm_r ? HR_WEEK : SEC_WEEK;
                    max_nxt = '0;
                    cm_nxt  = 8'h10;
                  end
                  8'h64: begin
                    mul_nxt = hm_r ? HR_DAY : SEC_DAY;
                    max_nxt = hm_r ? HR_WEEK : SEC_WEEK;
                    cm_nxt  = 8'h08;
                  end
                  8'h68: begin
                    mul_nxt = hm_r ? MUL_W'(1) : SEC_HOUR;
                    max_nxt = hm_r ? HR_DAY : SEC_DAY;
                    cm_nxt  = 8'h04;
                  end
                  8'h6D: begin
                    mul_nxt = SEC_MIN;
                    max_nxt = SEC_HOUR;
                    cm_nxt  = 8'h02;
                    if (hm_r) st_nxt = S_IDLE;
                  end
                  8'h73: begin
                    mul_nxt = MUL_W'(1);
                    max_nxt = SEC_MIN;
                    cm_nxt  = 8'h01;
                    if (hm_r) st_nxt = S_IDLE;
                  end
                  default: st_nxt = S_IDLE;
                endcase
                if (st_nxt == S_IDLE) begin
                  fin = 1'b1; fst = ST_UNEXPECTED; fbad = c;
                end
              end
            end
            default: begin
              ph_nxt = PH_LEAD;
              if (blank) begin
              end else if (digit) begin
                num_nxt = {28'd0, c[3:0]};
                dc_nxt  = 5'd1;
                ph_nxt  = PH_NUM;
              end else begin
                fin = 1'b1; fst = ST_UNEXPECTED; fbad = c;
              end
            end
          endcase
        end
      end
      S_MUL: begin
        v_nxt  = DIV_W'({num_r, {MUL_W{1'b0}}} >> MUL_W) * DIV_W'(mul_r);
        tm_nxt = DIV_W'(tot_r) * DIV_W'(mul_r);
        st_nxt = S_APPLY;
      end
      S_APPLY: begin
        fbyte = ch_r;
        chk   = mask_r & (MASK_BOTH | ((cm_r << 1) - 8'd1));
        st_nxt = S_IDLE;
        ph_nxt = PH_AFTER_SECTION;
        if (mask_r == MASK_DOT) begin
          dreq.start    = 1'b1;
          dreq.dividend = v_r;
          dn_nxt        = dc_r - 5'd1;
          st_nxt        = S_DIV;
        end else if (mask_r == 8'h00) begin
          mask_nxt = cm_r;
          sum      = {1'b0, v_r};
        end else if (chk == 8'h00) begin
          if (cm_r == 8'h10 || v_r < DIV_W'(max_r)) begin
            mask_nxt = mask_r | cm_r;
            sum      = {1'b0, v_r} + 53'(tot_r);
          end else begin
            fin = 1'b1; fst = ST_TOO_BIG; fbad = ch_r;
          end
        end else begin
          fin = 1'b1; fst = ST_UNEXPECTED; fbad = ch_r;
        end
        if (st_nxt == S_IDLE && !fin) begin
          tot_nxt = sum[31:0];
          if (sum > 53'(U32_MAX)) begin
            fin = 1'b1; fst = ST_TOO_BIG;
          end
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          if (dn_r == 5'd0) begin
            st_nxt = S_FRAC;
          end else begin
            dreq.start = 1'b1;
            dn_nxt     = dn_r - 5'd1;
          end
        end
      end
      S_FRAC: begin
        fbyte    = ch_r;
        sum      = {1'b0, tm_r} + {1'b0, drsp.quo} + 53'(drsp.rem >= 4'd5);
        mask_nxt = mask_r | MASK_FRAC;
        tot_nxt  = sum[31:0];
        st_nxt   = S_IDLE;
        ph_nxt   = PH_AFTER_SECTION;
        if (sum > 53'(U32_MAX)) begin
          fin = 1'b1; fst = ST_TOO_BIG;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (fin) begin
      ov_nxt   = 1'b1;
      os_nxt   = fst;
      op_nxt   = fper;
      ob_nxt   = fbad;
      mask_nxt = '0;
      tot_nxt  = '0;
      num_nxt  = '0;
      dc_nxt   = '0;
      st_nxt   = S_IDLE;
      ph_nxt   = (fbyte == 8'h00) ? PH_LEAD : PH_DRAIN;
    end
  end

  always_ff @(posedge clk) begin
    cm_r  <= cm_nxt;
    ch_r  <= ch_nxt;
    dn_r  <= dn_nxt;
    mul_r <= mul_nxt;
    max_r <= max_nxt;
    v_r   <= v_nxt;
    tm_r  <= tm_nxt;
    os_r  <= os_nxt;
    op_r  <= op_nxt;
    ob_r  <= ob_nxt;
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ph_r   <= PH_LEAD;
      mask_r <= '0;
      tot_r  <= '0;
      num_r  <= '0;
      dc_r   <= '0;
      ov_r   <= 1'b0;
      hm_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      mask_r <= mask_nxt;
      tot_r  <= tot_nxt;
      num_r  <= num_nxt;
      dc_r   <= dc_nxt;
      ov_r   <= ov_nxt;
      if (cfg_valid && cfg_ready) hm_r <= cfg_hours_mode;
    end
  end

endmodule

// ----- sv/tpp_div10.sv -----
// Iterative divide by ten, four dividend bits per cycle.
module tpp_div10
  import tpp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CW = $clog2(DIV_NIB + 1);

  logic [DIV_W-1:0] sh_r, sh_nxt;
  logic [3:0]       rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    logic [4:0] r;
    logic [3:0] qn;
    r  = {1'b0, rem_r};
    qn = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[3:0], sh_r[DIV_W-4+i]};
      if (r >= 5'd10) begin
        r = r - 5'd10;
        qn[i] = 1'b1;
      end
    end
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      sh_nxt   = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DIV_NIB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[DIV_W-5:0], qn};
      rem_nxt = r[3:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = sh_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- sv/tpp_checker.sv -----
// Port-level checks for the time period parser, bound to the top level.
module tpp_checker
  import tpp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_period,
  input logic [7:0]  out_bad_char
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_TOO_BIG) else $error("bad status code");

  a_err_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_period == 32'd0)
    else $error("period on error beat");

  a_ok_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_bad_char == 8'd0)
    else $error("bad_char on ok beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_period))
    else $error("stalled beat changed");

endmodule

bind time_period_parser tpp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_status(out_status), .out_period(out_period), .out_bad_char(out_bad_char)
);
